### rtl/lsf_pkg.sv
// shared types, constants and helpers of the line substring filter
`default_nettype none

package lsf_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int CHUNK_BUFFER = 4096;

  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W     = $clog2(CHUNK_BUFFER);
  localparam int LINE_W    = 32;
  localparam int SEL_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0]  CHUNK_LAST = CNT_W'(CHUNK_BUFFER - 1);
  localparam logic [LINE_W-1:0] LINES_MAX  = '1;
  localparam logic [SEL_W-1:0]  SEL_MAX    = '1;
  localparam logic [7:0]        BYTE_LF    = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SELECT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = CFG_IDX_W'(5);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } lsf_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_no;
    logic              line_selected;
    logic              stop_reached;
  } lsf_out_t;

  // ascii upper case to lower case when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
    logic [7:0] r;
    r = b;
    if (fold_en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/line_substring_filter.sv
// top level of the line substring filter
//
// usage: a file enters as one item per byte on the in_ channel (valid/ready),
// with end_of_file set on its last byte. the block cuts the stream into
// line chunks, ending at a newline byte, after 4095 bytes or at end_of_file,
// and looks for the configured pattern (up to 16 bytes) in each chunk.
// at every chunk end up to the stop result one item leaves on the out_
// channel with the line number, the selection flag and the stop flag;
// other bytes give no item. a byte is taken into the input register, then
// compared against all window positions at once, and the result of a byte
// that ends the chunk is written to the output register behind out_valid.
// throughput: one byte per cycle while the output register is empty or
// being read; the byte in the input register waits whenever a result is
// held in the output register.
// stall: while out_ready is low the result holds, one more byte enters the
// input register and in_ready then drops until the result is taken.
// reset (rst_n low, synchronous): counts, window and flags clear, max_count
// returns to unlimited and the pattern to empty. configuration writes on
// cfg_we take effect at the next edge and belong where no item is in flight.
// after the stop result the block keeps taking bytes and drops them.
`default_nettype none

module line_substring_filter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire lsf_pkg::lsf_in_t               in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output lsf_pkg::lsf_out_t                   out_item,
  input  wire logic                           cfg_we,
  input  wire logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import lsf_pkg::*;

  // configuration registers
  logic                  ignore_case_r;
  logic                  invert_select_r;
  logic [SEL_W-1:0]      max_count_r;
  logic [4:0]            pattern_length_r;
  logic [63:0]           pattern_low_r;
  logic [63:0]           pattern_high_r;

  // input register
  logic                  in_valid_r, in_valid_nxt;
  lsf_in_t               in_item_r, in_item_nxt;

  // chunk and count state
  logic [7:0]            window_r   [PATTERN_MAX];
  logic [7:0]            window_nxt [PATTERN_MAX];
  logic [CNT_W-1:0]      chunk_cnt_r, chunk_cnt_nxt;
  logic                  found_r, found_nxt;
  logic                  zero_seen_r, zero_seen_nxt;
  logic [LINE_W-1:0]     lines_done_r, lines_done_nxt;
  logic [SEL_W-1:0]      sel_count_r, sel_count_nxt;
  logic                  halted_r, halted_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  lsf_out_t              out_item_r, out_item_nxt;

  // pattern derived from configuration
  logic [7:0]            pat_byte [PATTERN_MAX];
  logic [7:0]            pat_align [PATTERN_MAX];
  logic [LEN_W-1:0]      len_clamp;
  logic [LEN_W-1:0]      eff_len;

  // per-byte datapath
  logic                  advance;
  logic                  take_byte;
  logic [7:0]            cur_byte;
  logic [CNT_W-1:0]      cnt_inc;
  logic [7:0]            win_shift [PATTERN_MAX];
  logic                  push;
  logic                  win_match;
  logic                  chunk_end;
  logic                  found_final;
  logic                  selected;
  logic [LINE_W-1:0]     line_num;
  logic [SEL_W-1:0]      sel_new;
  logic                  stop;

  // the stage advances whenever the output register can take a result
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // pattern bytes, anything past the two registers reads as zero
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < 8) begin
        pat_byte[i] = pattern_low_r[8*(i%8) +: 8];
      end else if (i < 16) begin
        pat_byte[i] = pattern_high_r[8*(i%8) +: 8];
      end else begin
        pat_byte[i] = 8'h00;
      end
    end
  end

  // effective length: clamp, then cut at the first zero pattern byte
  always_comb begin
    if (5'(pattern_length_r) > 5'(PATTERN_MAX)) begin
      len_clamp = LEN_W'(PATTERN_MAX);
    end else begin
      len_clamp = LEN_W'(pattern_length_r);
    end
    eff_len = len_clamp;
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if (LEN_W'(i) < len_clamp && pat_byte[i] == 8'h00) begin
        eff_len = LEN_W'(i);
      end
    end
  end

  // pattern reversed so that entry k lines up with window entry k (newest first)
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pat_align[k] = 8'h00;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
        if (k < l && eff_len == LEN_W'(l)) begin
          pat_align[k] = fold_byte(pat_byte[l-1-k], ignore_case_r);
        end
      end
    end
  end

  assign cur_byte  = in_item_r.data_byte;
  assign cnt_inc   = chunk_cnt_r + 1'b1;
  assign push      = !zero_seen_r && (cur_byte != 8'h00);
  assign take_byte = advance && !halted_r;
  assign chunk_end = (cur_byte == BYTE_LF) || in_item_r.end_of_file ||
                     (cnt_inc >= CHUNK_LAST);

  // window after this byte goes in
  always_comb begin
    win_shift[0] = fold_byte(cur_byte, ignore_case_r);
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_shift[k] = window_r[k-1];
    end
  end

  // all window positions compared at once
  always_comb begin
    win_match = (eff_len != '0) && (cnt_inc >= CNT_W'(eff_len));
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LEN_W'(k) < eff_len && win_shift[k] != pat_align[k]) begin
        win_match = 1'b0;
      end
    end
  end

  // chunk bookkeeping and result
  always_comb begin
    window_nxt     = window_r;
    chunk_cnt_nxt  = chunk_cnt_r;
    found_nxt      = found_r;
    zero_seen_nxt  = zero_seen_r;
    lines_done_nxt = lines_done_r;
    sel_count_nxt  = sel_count_r;
    halted_nxt     = halted_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;

    found_final = found_r || (push && win_match) || (eff_len == '0);
    selected    = found_final ^ invert_select_r;
    line_num    = (lines_done_r != LINES_MAX) ? lines_done_r + 1'b1 : lines_done_r;
    sel_new     = (selected && sel_count_r != SEL_MAX) ? sel_count_r + 1'b1 : sel_count_r;
    // a set sign bit means no limit
    stop        = !max_count_r[SEL_W-1] && (sel_new >= max_count_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (take_byte) begin
      if (chunk_end) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          window_nxt[k] = 8'h00;
        end
        chunk_cnt_nxt  = '0;
        found_nxt      = 1'b0;
        zero_seen_nxt  = 1'b0;
        lines_done_nxt = line_num;
        sel_count_nxt  = sel_new;
        halted_nxt     = stop;
        out_valid_nxt  = 1'b1;
        out_item_nxt.line_no       = line_num;
        out_item_nxt.line_selected = selected;
        out_item_nxt.stop_reached  = stop;
      end else begin
        chunk_cnt_nxt = cnt_inc;
        if (!zero_seen_r) begin
          if (cur_byte == 8'h00) begin
            zero_seen_nxt = 1'b1;
          end else begin
            window_nxt = win_shift;
            found_nxt  = found_r || win_match;
          end
        end
      end
    end
  end

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      chunk_cnt_r  <= '0;
      found_r      <= 1'b0;
      zero_seen_r  <= 1'b0;
      lines_done_r <= '0;
      sel_count_r  <= '0;
      halted_r     <= 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window_r[k] <= 8'h00;
      end
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      chunk_cnt_r  <= chunk_cnt_nxt;
      found_r      <= found_nxt;
      zero_seen_r  <= zero_seen_nxt;
      lines_done_r <= lines_done_nxt;
      sel_count_r  <= sel_count_nxt;
      halted_r     <= halted_nxt;
      window_r     <= window_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_case_r    <= 1'b0;
      invert_select_r  <= 1'b0;
      max_count_r      <= '1;
      pattern_length_r <= '0;
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IGNORE_CASE:    ignore_case_r    <= cfg_wdata[0];
        CFG_INVERT_SELECT:  invert_select_r  <= cfg_wdata[0];
        CFG_MAX_COUNT:      max_count_r      <= cfg_wdata[SEL_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[4:0];
        CFG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lsf_checker.sv
// port-level checks of the line substring filter and their binding
`default_nettype none

module lsf_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire lsf_pkg::lsf_in_t  in_item,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire lsf_pkg::lsf_out_t out_item
);

  import lsf_pkg::*;

  // no result leaves right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("waiting input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // nothing follows the stop result
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.stop_reached |=> !out_valid)
    else $error("result after stop");

  // line numbers count from one
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.line_no != '0)
    else $error("line number zero");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (.*);

`default_nettype wire
